// ----- sv/scla_pkg.sv -----
// shared types and constants for the serial command line assembler
`timescale 1ns / 1ps

package scla_pkg;

  // line store geometry
  localparam int LINE_CAPACITY = 64;
  localparam int FILL_W        = $clog2(LINE_CAPACITY);

  // fixed field widths
  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int LEN_W   = 6;
  localparam int IDLE_W  = 17;
  localparam int GARB_W  = 9;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GARBAGE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd2;

  // register reset values
  localparam logic [15:0] IDLE_LIMIT_RST    = 16'd500;
  localparam logic [7:0]  GARBAGE_LIMIT_RST = 8'd20;
  localparam logic [5:0]  MIN_LENGTH_RST    = 6'd2;

  // byte codes
  localparam logic [BYTE_W-1:0] CHAR_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] PRINTABLE_LO   = 8'h20;
  localparam logic [BYTE_W-1:0] PRINTABLE_HI   = 8'h7E;

  // saturation value of the idle counter
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  // request from intake to emitter: start sending a completed line
  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] length;
  } emit_req_t;

  // store write request from intake
  typedef struct packed {
    logic              we;
    logic [FILL_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } store_wr_t;

endpackage

// ----- sv/scla_line_ram.sv -----
// line store: one write port, one registered read port
`timescale 1ns / 1ps

module scla_line_ram (
  input  logic                              clk,
  input  scla_pkg::store_wr_t               wr,
  input  logic [scla_pkg::FILL_W-1:0]       raddr,
  output logic [scla_pkg::CHAR_W-1:0]       rdata
);

  logic [scla_pkg::CHAR_W-1:0] mem [scla_pkg::LINE_CAPACITY];
  logic [scla_pkg::CHAR_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/scla_intake.sv -----
// byte intake: config registers, line counters and store writes
`timescale 1ns / 1ps

module scla_intake (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scla_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                byte_valid,
  input  logic [scla_pkg::BYTE_W-1:0]         byte_data,
  output scla_pkg::store_wr_t                 wr,
  output scla_pkg::emit_req_t                 req
);

  logic [15:0]                   idle_limit_r;
  logic [7:0]                    garbage_limit_r;
  logic [5:0]                    min_length_r;
  logic [scla_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [scla_pkg::GARB_W-1:0]   garb_r, garb_nxt;
  logic [scla_pkg::IDLE_W-1:0]   idle_r, idle_nxt;
  logic [scla_pkg::FILL_W-1:0]   fill_a;
  logic [scla_pkg::GARB_W-1:0]   garb_a;
  logic [scla_pkg::IDLE_W-1:0]   idle_a;
  logic [scla_pkg::GARB_W-1:0]   garb_inc;
  logic                          is_term;
  logic                          is_print;
  logic                          long_enough;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r    <= scla_pkg::IDLE_LIMIT_RST;
      garbage_limit_r <= scla_pkg::GARBAGE_LIMIT_RST;
      min_length_r    <= scla_pkg::MIN_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scla_pkg::REG_IDLE_LIMIT:    idle_limit_r    <= cfg_wdata;
        scla_pkg::REG_GARBAGE_LIMIT: garbage_limit_r <= cfg_wdata[7:0];
        scla_pkg::REG_MIN_LENGTH:    min_length_r    <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // byte classification
  assign is_term  = (byte_data == scla_pkg::CHAR_CR) || (byte_data == scla_pkg::CHAR_LF);
  assign is_print = (byte_data >= scla_pkg::PRINTABLE_LO) &&
                    (byte_data <= scla_pkg::PRINTABLE_HI);

  // counter update for one byte
  always_comb begin
    // idle count saturates; a partial line left idle past the limit is dropped
    idle_a = (idle_r != scla_pkg::IDLE_MAX) ? idle_r + 1'b1 : idle_r;
    fill_a = fill_r;
    garb_a = garb_r;
    if ((fill_r != '0) && (idle_a > {1'b0, idle_limit_r})) begin
      fill_a = '0;
      garb_a = '0;
      idle_a = '0;
    end

    long_enough = (scla_pkg::LEN_W'(fill_a) >= min_length_r);
    garb_inc    = garb_a + 1'b1;

    fill_nxt = fill_a;
    garb_nxt = garb_a;
    idle_nxt = idle_a;
    wr.we    = 1'b0;
    wr.addr  = fill_a;
    wr.data  = byte_data[scla_pkg::CHAR_W-1:0];
    req.start  = 1'b0;
    req.length = fill_a;

    if (is_term) begin
      if (long_enough) begin
        req.start = byte_valid && (fill_a != '0);
        fill_nxt  = '0;
        garb_nxt  = '0;
        idle_nxt  = '0;
      end else begin
        fill_nxt = '0;
      end
    end else if (is_print) begin
      if (fill_a < scla_pkg::FILL_W'(scla_pkg::LINE_CAPACITY - 1)) begin
        wr.we    = byte_valid;
        fill_nxt = fill_a + 1'b1;
        idle_nxt = '0;
        garb_nxt = '0;
      end
    end else begin
      // garbage byte
      garb_nxt = garb_inc;
      if (garb_inc > {1'b0, garbage_limit_r}) begin
        fill_nxt = '0;
        garb_nxt = '0;
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      garb_r <= '0;
      idle_r <= '0;
    end else if (byte_valid) begin
      fill_r <= fill_nxt;
      garb_r <= garb_nxt;
      idle_r <= idle_nxt;
    end
  end

endmodule

// ----- sv/scla_emitter.sv -----
// line emitter: walks the store and presents each character of a requested line
`timescale 1ns / 1ps

module scla_emitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scla_pkg::emit_req_t                 req,
  output logic                                busy,
  output logic [scla_pkg::FILL_W-1:0]         raddr,
  input  logic [scla_pkg::CHAR_W-1:0]         rdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scla_pkg::CHAR_W-1:0]         out_char,
  output logic [scla_pkg::LEN_W-1:0]          out_length,
  output logic                                out_last
);

  localparam logic [1:0] EM_IDLE  = 2'd0;
  localparam logic [1:0] EM_FETCH = 2'd1;
  localparam logic [1:0] EM_SHOW  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [scla_pkg::FILL_W-1:0] ptr_r, ptr_nxt;
  logic [scla_pkg::FILL_W-1:0] len_r, len_nxt;
  logic                        last;

  assign last = (ptr_r == len_r - 1'b1);

  // sequencer: fetch a character, then hold it until taken
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    len_nxt   = len_r;
    unique case (state_r)
      EM_IDLE: begin
        if (req.start) begin
          len_nxt   = req.length;
          ptr_nxt   = '0;
          state_nxt = EM_FETCH;
        end
      end
      EM_FETCH: begin
        state_nxt = EM_SHOW;
      end
      EM_SHOW: begin
        if (out_ready) begin
          if (last) begin
            state_nxt = EM_IDLE;
          end else begin
            ptr_nxt   = ptr_r + 1'b1;
            state_nxt = EM_FETCH;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  // the store read register holds the character while it is shown
  assign raddr      = ptr_r;
  assign busy       = (state_r != EM_IDLE);
  assign out_valid  = (state_r == EM_SHOW);
  assign out_char   = rdata;
  assign out_length = scla_pkg::LEN_W'(len_r);
  assign out_last   = last;

endmodule

// ----- sv/serial_command_line_assembler.sv -----
// top level of the serial command line assembler
//
//   channel   direction  handshake              payload
//   in_       request    in_tvalid/in_tready    in_tdata: rx_byte
//   out_      result     out_tvalid/out_tready  out_tdata: line_char, line_length; tlast
//   cfg_      write      cfg_we                 cfg_index, cfg_wdata
//
// an ordinary byte is taken every cycle while no line is being sent; counters update in the same cycle
// a terminator that completes a line stalls input while the line is sent
// each character passes a store read state, then a show state, where it waits out output stalls
// reset is synchronous, active low; the line store needs no clearing pass
// output stalls hold the current character on the store read register
`timescale 1ns / 1ps

module serial_command_line_assembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [6:0] line_char, [12:7] line_length, [15:13] zero
  output logic        out_tlast     // last_char
);

  scla_pkg::store_wr_t               wr;
  scla_pkg::emit_req_t               req;
  logic                              busy;
  logic                              in_acc;
  logic [scla_pkg::FILL_W-1:0]       raddr;
  logic [scla_pkg::CHAR_W-1:0]       rdata;
  logic [scla_pkg::CHAR_W-1:0]       out_char;
  logic [scla_pkg::LEN_W-1:0]        out_length;

  // input stalls while a line is sent
  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;

  scla_intake u_intake (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (in_acc),
    .byte_data  (in_tdata),
    .wr         (wr),
    .req        (req)
  );

  scla_line_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  scla_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .busy       (busy),
    .raddr      (raddr),
    .rdata      (rdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_char),
    .out_length (out_length),
    .out_last   (out_tlast)
  );

  // result packing
  assign out_tdata = {3'b000, out_length, out_char};

endmodule
